### rtl/stack_machine_core_defines.svh
// Assertion macros for the stack machine RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef STACK_MACHINE_CORE_DEFINES_SVH
`define STACK_MACHINE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define SMC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/smc_pkg.sv
// Package for the stack machine core: status codes, opcodes, argument types
// and sequencer states. No dependencies.
package smc_pkg;

    localparam int IP_W     = 7;
    localparam int WORD_W   = 32;
    localparam int EXEC_CAP = 100;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_OUT    = 3'd1,
        ST_HALT   = 3'd2,
        ST_BADARG = 3'd3,
        ST_BADOP  = 3'd4,
        ST_FAULT  = 3'd5
    } status_t;

    localparam logic [4:0] OP_HLT  = 5'd1;
    localparam logic [4:0] OP_PUSH = 5'd2;
    localparam logic [4:0] OP_POP  = 5'd3;
    localparam logic [4:0] OP_IN   = 5'd4;
    localparam logic [4:0] OP_OUT  = 5'd5;
    localparam logic [4:0] OP_ADD  = 5'd6;
    localparam logic [4:0] OP_SUB  = 5'd7;
    localparam logic [4:0] OP_MUL  = 5'd8;
    localparam logic [4:0] OP_DIV  = 5'd9;
    localparam logic [4:0] OP_JMP  = 5'd10;
    localparam logic [4:0] OP_JB   = 5'd11;
    localparam logic [4:0] OP_JBE  = 5'd12;
    localparam logic [4:0] OP_JA   = 5'd13;
    localparam logic [4:0] OP_JAE  = 5'd14;
    localparam logic [4:0] OP_JE   = 5'd15;
    localparam logic [4:0] OP_JNE  = 5'd16;
    localparam logic [4:0] OP_CALL = 5'd17;
    localparam logic [4:0] OP_RET  = 5'd18;

    // argument type field, word bits 7..5: memory, register, immediate
    localparam logic [2:0] ARG_NONE = 3'b000;
    localparam logic [2:0] ARG_MEM  = 3'b100;
    localparam logic [2:0] ARG_REG  = 3'b010;
    localparam int         BIT_MEM  = 2;
    localparam int         BIT_REG  = 1;
    localparam int         BIT_IMM  = 0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OP_REQ,
        S_OP_GET,
        S_IDX_REQ,
        S_IDX_GET,
        S_IMM_REQ,
        S_IMM_GET,
        S_EXEC,
        S_POP1,
        S_POP2,
        S_MEM_GET,
        S_DIV,
        S_DIV_FIX,
        S_WB,
        S_DONE
    } state_t;

endpackage

### rtl/smc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module smc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/stack_machine_core.sv
// Stack machine core top level: sequencer, stacks, register file, divider.
// Depends on smc_pkg, smc_ram and stack_machine_core_defines.svh.
//
// Usage: each s_ transaction is a load (s_tuser 0: write code_word at
// code_address) or a step (s_tuser 1: execute one instruction, with in_value
// offered to IN). Every input transaction returns exactly one m_ transaction
// carrying a status in m_tuser and out_value, program_counter, input_taken.
// The core takes one transaction at a time; s_tready is high only while the
// sequencer is idle. A load and a step on a halted core go straight to the
// result; for other steps the time is set by the code words read and the
// stack and data memory accesses, and a divide runs 32 radix-2 iterations
// plus a sign fix. The result becomes valid as the sequencer returns to idle.
// All code, data stack and data memory reads go through single registered
// read ports, one per cycle.
// Reset clears stack pointers, instruction pointer, halt flag, register file
// and the valid bits of data memory; code memory is undefined until loaded.
// A finished result sits in the output register; while the receiver stalls
// the core still accepts and works the next transaction, then waits to hand
// its result over.
`include "stack_machine_core_defines.svh"

module stack_machine_core import smc_pkg::*; #(
    parameter int CODE_DEPTH   = 128,
    parameter int STACK_DEPTH  = 16,
    parameter int RETURN_DEPTH = 16,
    parameter int REG_COUNT    = 4,
    parameter int DATA_WORDS   = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // code_address[6:0], code_word[38:7], in_value[70:39]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_value[31:0], program_counter[38:32], input_taken[39]
    output logic [2:0]  m_tuser    // status
);

    localparam int LIMIT = (CODE_DEPTH < EXEC_CAP) ? CODE_DEPTH : EXEC_CAP;
    localparam int CAW   = $clog2(CODE_DEPTH);
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int RAW   = $clog2(RETURN_DEPTH);
    localparam int RPW   = $clog2(RETURN_DEPTH + 1);
    localparam int RGW   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int DAW   = $clog2(DATA_WORDS);

    state_t            state_reg, state_next;
    logic [IP_W-1:0]   ip_reg, ip_next;
    logic              halted_reg, halted_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [RPW-1:0]    rsp_reg, rsp_next;
    logic [4:0]        op_reg, op_next;
    logic [2:0]        t_reg, t_next;
    logic [RGW-1:0]    idx_reg, idx_next;
    logic              ok_reg, ok_next;
    logic [31:0]       sum_reg, sum_next;
    logic [31:0]       b_reg, b_next;
    logic [31:0]       res_reg, res_next;
    logic [31:0]       r_reg, r_next;
    logic [31:0]       q_reg, q_next;
    logic [31:0]       d_reg, d_next;
    logic              neg_reg, neg_next;
    logic [4:0]        cnt_reg, cnt_next;
    status_t           status_reg, status_next;
    logic [31:0]       outv_reg, outv_next;
    logic              taken_reg, taken_next;
    logic [31:0]       in_reg, in_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [2:0]        m_status_reg, m_status_next;
    logic [39:0]       m_data_reg, m_data_next;

    logic [31:0]       regfile_reg [REG_COUNT];
    logic [IP_W-1:0]   retstk_reg [RETURN_DEPTH];
    logic              dvalid_reg [DATA_WORDS];

    logic              code_we;
    logic [31:0]       code_rdata, word;
    logic [31:0]       addr_ext, ip_ext;
    logic              stk_we;
    logic [SAW-1:0]    stk_waddr, stk_raddr;
    logic [31:0]       stk_wdata, stk_rdata;
    logic              dm_we;
    logic [31:0]       dm_rdata;
    logic              rf_we;
    logic              rs_we;
    logic              dv_set;
    logic [SPW-1:0]    sp_m1, sp_m2;
    logic [RPW-1:0]    rsp_m1;
    logic [32:0]       trial;
    logic [31:0]       a_val;
    logic              cmp_hit;

    function automatic logic [IP_W-1:0] jump_to(input logic [31:0] tgt);
        return (tgt < 32'(LIMIT)) ? tgt[IP_W-1:0] : IP_W'(LIMIT);
    endfunction

    assign addr_ext = 32'(s_tdata[6:0]);
    assign ip_ext   = 32'(ip_reg);
    assign word     = (ip_ext < 32'(CODE_DEPTH)) ? code_rdata : 32'd0;
    assign sp_m1    = sp_reg - SPW'(1);
    assign sp_m2    = sp_reg - SPW'(2);
    assign rsp_m1   = rsp_reg - RPW'(1);
    assign a_val    = stk_rdata;
    assign trial    = {r_reg, q_reg[31]} - {1'b0, d_reg};

    assign stk_raddr = (state_reg == S_POP1) ? sp_m2[SAW-1:0] : sp_m1[SAW-1:0];

    smc_ram #(.WIDTH(32), .DEPTH(CODE_DEPTH)) u_code (
        .aclk(aclk), .we(code_we), .waddr(addr_ext[CAW-1:0]), .wdata(s_tdata[38:7]),
        .raddr(ip_ext[CAW-1:0]), .rdata(code_rdata)
    );

    smc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    smc_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_data (
        .aclk(aclk), .we(dm_we), .waddr(sum_reg[DAW-1:0]), .wdata(stk_rdata),
        .raddr(sum_reg[DAW-1:0]), .rdata(dm_rdata)
    );

    always_comb begin
        case (op_reg)
            OP_JB:   cmp_hit = $signed(a_val) <  $signed(b_reg);
            OP_JBE:  cmp_hit = $signed(a_val) <= $signed(b_reg);
            OP_JA:   cmp_hit = $signed(a_val) >  $signed(b_reg);
            OP_JAE:  cmp_hit = $signed(a_val) >= $signed(b_reg);
            OP_JE:   cmp_hit = a_val == b_reg;
            default: cmp_hit = a_val != b_reg;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        ip_next       = ip_reg;
        halted_next   = halted_reg;
        sp_next       = sp_reg;
        rsp_next      = rsp_reg;
        op_next       = op_reg;
        t_next        = t_reg;
        idx_next      = idx_reg;
        ok_next       = ok_reg;
        sum_next      = sum_reg;
        b_next        = b_reg;
        res_next      = res_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        d_next        = d_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        status_next   = status_reg;
        outv_next     = outv_reg;
        taken_next    = taken_reg;
        in_next       = in_reg;
        m_tvalid_next = m_tvalid_reg;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        code_we       = 1'b0;
        stk_we        = 1'b0;
        stk_waddr     = sp_reg[SAW-1:0];
        stk_wdata     = sum_reg;
        dm_we         = 1'b0;
        rf_we         = 1'b0;
        rs_we         = 1'b0;
        dv_set        = 1'b0;
        s_tready      = (state_reg == S_IDLE);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    in_next     = s_tdata[70:39];
                    status_next = ST_OK;
                    outv_next   = 32'd0;
                    taken_next  = 1'b0;
                    if (!s_tuser) begin
                        code_we    = addr_ext < 32'(CODE_DEPTH);
                        state_next = S_DONE;
                    end else if (halted_reg || ip_ext >= 32'(LIMIT)) begin
                        halted_next = 1'b1;
                        status_next = ST_HALT;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_OP_REQ;
                    end
                end
            end
            S_OP_REQ: state_next = S_OP_GET;
            S_OP_GET: begin
                if (word == 32'd0) begin
                    halted_next = 1'b1;
                    status_next = ST_HALT;
                    state_next  = S_DONE;
                end else begin
                    ip_next  = ip_reg + IP_W'(1);
                    op_next  = word[4:0];
                    t_next   = word[7:5];
                    ok_next  = 1'b1;
                    sum_next = 32'd0;
                    case (word[4:0])
                        OP_HLT: begin
                            halted_next = 1'b1;
                            status_next = ST_HALT;
                            state_next  = S_DONE;
                        end
                        OP_PUSH, OP_POP: begin
                            if (word[7:5] == ARG_NONE || word[7:5] == ARG_MEM) begin
                                status_next = ST_BADARG;
                                state_next  = S_DONE;
                            end else if (word[5 + BIT_REG]) begin
                                state_next = S_IDX_REQ;
                            end else begin
                                state_next = S_IMM_REQ;
                            end
                        end
                        OP_IN, OP_OUT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_RET: begin
                            state_next = S_EXEC;
                        end
                        OP_JMP, OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE, OP_CALL: begin
                            state_next = S_IMM_REQ;
                        end
                        default: begin
                            status_next = ST_BADOP;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_IDX_REQ: state_next = S_IDX_GET;
            S_IDX_GET: begin
                ip_next = ip_reg + IP_W'(1);
                if (word < 32'(REG_COUNT)) begin
                    idx_next = word[RGW-1:0];
                    sum_next = regfile_reg[word[RGW-1:0]];
                end else begin
                    ok_next = 1'b0;
                end
                state_next = t_reg[BIT_IMM] ? S_IMM_REQ : S_EXEC;
            end
            S_IMM_REQ: state_next = S_IMM_GET;
            S_IMM_GET: begin
                ip_next    = ip_reg + IP_W'(1);
                sum_next   = (op_reg == OP_PUSH || op_reg == OP_POP) ? sum_reg + word : word;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_DONE;
                case (op_reg)
                    OP_PUSH: begin
                        if (!ok_reg || (t_reg[BIT_MEM] && sum_reg >= 32'(DATA_WORDS)) ||
                            sp_reg >= SPW'(STACK_DEPTH)) begin
                            status_next = ST_FAULT;
                        end else if (t_reg[BIT_MEM]) begin
                            state_next = S_MEM_GET;
                        end else begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + SPW'(1);
                        end
                    end
                    OP_POP, OP_OUT: begin
                        if ((op_reg == OP_POP && (!ok_reg ||
                             (t_reg[BIT_MEM] && sum_reg >= 32'(DATA_WORDS)))) ||
                            sp_reg == SPW'(0)) begin
                            status_next = ST_FAULT;
                        end else begin
                            state_next = S_POP1;
                        end
                    end
                    OP_IN: begin
                        if (sp_reg >= SPW'(STACK_DEPTH)) begin
                            status_next = ST_FAULT;
                        end else begin
                            stk_we     = 1'b1;
                            stk_wdata  = in_reg;
                            sp_next    = sp_reg + SPW'(1);
                            taken_next = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                    OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
                        if (sp_reg < SPW'(2)) begin
                            status_next = ST_FAULT;
                        end else begin
                            state_next = S_POP1;
                        end
                    end
                    OP_JMP: ip_next = jump_to(sum_reg);
                    OP_CALL: begin
                        if (rsp_reg >= RPW'(RETURN_DEPTH)) begin
                            status_next = ST_FAULT;
                        end else begin
                            rs_we    = 1'b1;
                            rsp_next = rsp_reg + RPW'(1);
                            ip_next  = jump_to(sum_reg);
                        end
                    end
                    OP_RET: begin
                        if (rsp_reg == RPW'(0)) begin
                            status_next = ST_FAULT;
                        end else begin
                            rsp_next = rsp_m1;
                            ip_next  = jump_to(32'(retstk_reg[rsp_m1[RAW-1:0]]));
                        end
                    end
                    default: status_next = ST_BADOP;
                endcase
            end
            S_POP1: begin
                state_next = S_DONE;
                case (op_reg)
                    OP_POP: begin
                        rf_we   = (t_reg == ARG_REG);
                        dm_we   = t_reg[BIT_MEM];
                        dv_set  = t_reg[BIT_MEM];
                        sp_next = sp_m1;
                    end
                    OP_OUT: begin
                        outv_next   = stk_rdata;
                        status_next = ST_OUT;
                        sp_next     = sp_m1;
                    end
                    default: begin
                        b_next     = stk_rdata;
                        state_next = S_POP2;
                    end
                endcase
            end
            S_POP2: begin
                state_next = S_WB;
                case (op_reg)
                    OP_ADD: res_next = a_val + b_reg;
                    OP_SUB: res_next = a_val - b_reg;
                    OP_MUL: res_next = a_val * b_reg;
                    OP_DIV: begin
                        if (b_reg == 32'd0) begin
                            status_next = ST_FAULT;
                            state_next  = S_DONE;
                        end else begin
                            r_next     = 32'd0;
                            q_next     = a_val[31] ? -a_val : a_val;
                            d_next     = b_reg[31] ? -b_reg : b_reg;
                            neg_next   = a_val[31] ^ b_reg[31];
                            cnt_next   = 5'd0;
                            state_next = S_DIV;
                        end
                    end
                    default: begin
                        sp_next = sp_m2;
                        if (cmp_hit) begin
                            ip_next = jump_to(sum_reg);
                        end
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DIV: begin
                if (!trial[32]) begin
                    r_next = trial[31:0];
                    q_next = {q_reg[30:0], 1'b1};
                end else begin
                    r_next = {r_reg[30:0], q_reg[31]};
                    q_next = {q_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = S_DIV_FIX;
                end
            end
            S_DIV_FIX: begin
                res_next   = neg_reg ? -q_reg : q_reg;
                state_next = S_WB;
            end
            S_WB: begin
                stk_we     = 1'b1;
                stk_waddr  = sp_m2[SAW-1:0];
                stk_wdata  = res_reg;
                sp_next    = sp_m1;
                state_next = S_DONE;
            end
            S_MEM_GET: begin
                stk_we     = 1'b1;
                stk_wdata  = dvalid_reg[sum_reg[DAW-1:0]] ? dm_rdata : 32'd0;
                sp_next    = sp_reg + SPW'(1);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_data_next   = {taken_reg, ip_reg, outv_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ip_reg       <= '0;
            halted_reg   <= 1'b0;
            sp_reg       <= '0;
            rsp_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                regfile_reg[i] <= 32'd0;
            end
            for (int i = 0; i < DATA_WORDS; i++) begin
                dvalid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg    <= state_next;
            ip_reg       <= ip_next;
            halted_reg   <= halted_next;
            sp_reg       <= sp_next;
            rsp_reg      <= rsp_next;
            m_tvalid_reg <= m_tvalid_next;
            if (rf_we) begin
                regfile_reg[idx_reg] <= stk_rdata;
            end
            if (dv_set) begin
                dvalid_reg[sum_reg[DAW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        t_reg        <= t_next;
        idx_reg      <= idx_next;
        ok_reg       <= ok_next;
        sum_reg      <= sum_next;
        b_reg        <= b_next;
        res_reg      <= res_next;
        r_reg        <= r_next;
        q_reg        <= q_next;
        d_reg        <= d_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        status_reg   <= status_next;
        outv_reg     <= outv_next;
        taken_reg    <= taken_next;
        in_reg       <= in_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        if (rs_we) begin
            retstk_reg[rsp_reg[RAW-1:0]] <= ip_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_data_reg;

    `SMC_ASSERT_IMP(a_sp_range, 1'b1, sp_reg <= SPW'(STACK_DEPTH), "data stack pointer out of range")
    `SMC_ASSERT_IMP(a_rsp_range, 1'b1, rsp_reg <= RPW'(RETURN_DEPTH), "return pointer out of range")
    `SMC_ASSERT_NXT(a_halt_sticky, halted_reg, halted_reg, "halt flag cleared without reset")
    `SMC_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, state_reg != S_IDLE, "idle after accept")

endmodule

### verif/stack_machine_core_tb.sv
// Self-checking testbench for stack_machine_core: builds programs on the fly
// over the load/step stream and compares each result with an in-bench model.
// Depends on smc_pkg and the stack_machine_core RTL.
module stack_machine_core_tb;
    import smc_pkg::*;

    typedef struct {
        status_t     st;
        logic [31:0] outv;
        logic [6:0]  pc;
        logic        taken;
    } smc_result_t;

    class smc_scoreboard;
        logic [31:0] code [128];
        logic [31:0] dstk [16];
        int unsigned rstk [16];
        logic [31:0] regs [4];
        logic [31:0] dmem [64];
        int unsigned sp, rsp, ip;
        bit          halted;
        smc_result_t pending_q [$];
        int          errors, results, steps, loads;
        int          status_seen [6];

        function new();
            foreach (code[i]) code[i] = '0;
            foreach (dstk[i]) dstk[i] = '0;
            foreach (rstk[i]) rstk[i] = 0;
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
        endfunction

        function logic [31:0] fetch();
            logic [31:0] w;
            w = (ip < 128) ? code[ip] : '0;
            ip++;
            return w;
        endfunction

        function void jump_to(logic [31:0] tgt);
            ip = (tgt < EXEC_CAP) ? tgt : EXEC_CAP;
        endfunction

        // kind: 0 value, 1 register, 2 memory
        function bit resolve(logic [2:0] t, output int kind, output logic [31:0] where,
                             output logic [31:0] val);
            logic [31:0] sum, idx;
            bit ok;
            sum = '0; ok = 1; kind = 0; where = '0; val = '0;
            if (t == ARG_REG) begin
                idx = fetch();
                kind = 1;
                where = idx;
                return idx < 4;
            end
            if (t[BIT_REG]) begin
                idx = fetch();
                if (idx < 4) sum += regs[idx];
                else ok = 0;
            end
            if (t[BIT_IMM]) sum += fetch();
            if (t[BIT_MEM]) begin
                kind = 2;
                where = sum;
                return ok && sum < 64;
            end
            val = sum;
            return ok;
        endfunction

        function void note(bit kind, logic [6:0] addr, logic [31:0] word, logic [31:0] inv);
            smc_result_t r;
            logic [31:0] w, a, b, val, where, tgt;
            logic [4:0]  op;
            logic [2:0]  t;
            int          k;
            bit          cond;
            r.st = ST_OK; r.outv = '0; r.taken = 0;
            if (!kind) begin
                code[addr] = word;
                loads++;
            end else if (halted || ip >= EXEC_CAP || code[ip] == 0) begin
                halted = 1;
                r.st = ST_HALT;
                steps++;
            end else begin
                steps++;
                w = fetch();
                op = w[4:0];
                t = w[7:5];
                case (op)
                    OP_HLT: begin
                        halted = 1;
                        r.st = ST_HALT;
                    end
                    OP_PUSH, OP_POP: begin
                        if (t == ARG_NONE || t == ARG_MEM) r.st = ST_BADARG;
                        else if (!resolve(t, k, where, val)) r.st = ST_FAULT;
                        else if (op == OP_PUSH) begin
                            if (sp >= 16) r.st = ST_FAULT;
                            else begin
                                if (k == 1) val = regs[where];
                                else if (k == 2) val = dmem[where];
                                dstk[sp] = val;
                                sp++;
                            end
                        end else begin
                            if (sp == 0) r.st = ST_FAULT;
                            else begin
                                val = dstk[sp - 1];
                                if (k == 1) regs[where] = val;
                                else if (k == 2) dmem[where] = val;
                                sp--;
                            end
                        end
                    end
                    OP_IN: begin
                        if (sp >= 16) r.st = ST_FAULT;
                        else begin
                            dstk[sp] = inv;
                            sp++;
                            r.taken = 1;
                        end
                    end
                    OP_OUT: begin
                        if (sp == 0) r.st = ST_FAULT;
                        else begin
                            r.outv = dstk[sp - 1];
                            sp--;
                            r.st = ST_OUT;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (sp < 2) r.st = ST_FAULT;
                        else begin
                            b = dstk[sp - 1];
                            a = dstk[sp - 2];
                            if (op == OP_ADD) val = a + b;
                            else if (op == OP_SUB) val = a - b;
                            else if (op == OP_MUL) val = a * b;
                            else if (b == 0) r.st = ST_FAULT;
                            else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) val = a;
                            else val = $signed(a) / $signed(b);
                            if (r.st == ST_OK) begin
                                dstk[sp - 2] = val;
                                sp--;
                            end
                        end
                    end
                    OP_JMP: jump_to(fetch());
                    OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
                        tgt = fetch();
                        if (sp < 2) r.st = ST_FAULT;
                        else begin
                            b = dstk[sp - 1];
                            a = dstk[sp - 2];
                            sp -= 2;
                            case (op)
                                OP_JB:   cond = $signed(a) <  $signed(b);
                                OP_JBE:  cond = $signed(a) <= $signed(b);
                                OP_JA:   cond = $signed(a) >  $signed(b);
                                OP_JAE:  cond = $signed(a) >= $signed(b);
                                OP_JE:   cond = a == b;
                                default: cond = a != b;
                            endcase
                            if (cond) jump_to(tgt);
                        end
                    end
                    OP_CALL: begin
                        tgt = fetch();
                        if (rsp >= 16) r.st = ST_FAULT;
                        else begin
                            rstk[rsp] = ip;
                            rsp++;
                            jump_to(tgt);
                        end
                    end
                    OP_RET: begin
                        if (rsp == 0) r.st = ST_FAULT;
                        else begin
                            rsp--;
                            jump_to(rstk[rsp]);
                        end
                    end
                    default: r.st = ST_BADOP;
                endcase
            end
            r.pc = ip[6:0];
            pending_q.push_back(r);
        endfunction

        function void check(logic [2:0] st, logic [31:0] outv, logic [6:0] pc, logic taken);
            smc_result_t e;
            results++;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result status %0d", st);
                return;
            end
            e = pending_q.pop_front();
            if (st < 6) status_seen[st]++;
            if (st !== e.st || outv !== e.outv || pc !== e.pc || taken !== e.taken) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: result %0d exp st=%0d out=%h pc=%0d in=%0d,",
                              " got st=%0d out=%h pc=%0d in=%0d"},
                             results, e.st, e.outv, e.pc, e.taken, st, outv, pc, taken);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    smc_scoreboard sb = new();
    bit quiet = 0;
    int items = 0;
    int stall_left = 0;
    int mode = 0;

    stack_machine_core u_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(9) == 0) begin
            stall_left <= $urandom_range(6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            sb.check(m_tuser, m_tdata[31:0], m_tdata[38:32], m_tdata[39]);

    task automatic send(bit kind, logic [6:0] addr, logic [31:0] word, logic [31:0] inv);
        if (!quiet && $urandom_range(7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge aclk);
        end
        s_tdata  <= {1'b0, inv, word, addr};
        s_tuser  <= kind;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note(kind, addr, word, inv);
        items++;
    endtask

    // load the instruction and its argument words at the current ip, then step it
    task automatic run_instr(int n, logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                             logic [31:0] inv);
        logic [6:0] at;
        at = sb.ip[6:0];
        send(0, at, w0, $urandom);
        if (n > 1) send(0, at + 7'd1, w1, $urandom);
        if (n > 2) send(0, at + 7'd2, w2, $urandom);
        send(1, 7'($urandom), $urandom, inv);
    endtask

    function automatic logic [31:0] mk(logic [4:0] op, logic [2:0] t);
        return {24'h0, t, op};
    endfunction

    function automatic logic [31:0] corner();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'h1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return $urandom_range(20);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_instr();
        logic [31:0] w, args [2];
        logic [31:0] idx, imm;
        logic [4:0]  op;
        logic [2:0]  t;
        int          n, sel;
        if (sb.ip > 95) begin
            run_instr(2, {24'($urandom), 3'($urandom), OP_JMP},
                      $urandom_range(60), 0, $urandom);
            return;
        end
        sel = $urandom_range(99);
        case (mode)
            1: op = (sel < 60) ? (sel[0] ? OP_PUSH : OP_IN) : 5'($urandom_range(5, 18));
            2: op = (sel < 50) ? (sel[0] ? OP_POP : OP_OUT) : 5'($urandom_range(6, 18));
            3: op = (sel < 50) ? (sel[0] ? OP_CALL : OP_RET) : 5'($urandom_range(2, 16));
            default: op = 5'($urandom_range(2, 18));
        endcase
        if (sel > 96) op = 5'($urandom_range(19, 31));
        else if (sel == 96) op = 5'd0;
        t = 3'($urandom);
        n = 0;
        if (op == OP_PUSH || op == OP_POP) begin
            if ($urandom_range(9) != 0)
                while (t == ARG_NONE || t == ARG_MEM) t = 3'($urandom);
            if (t != ARG_NONE && t != ARG_MEM) begin
                idx = ($urandom_range(11) == 0) ? $urandom_range(4, 40) : $urandom_range(3);
                if (t[BIT_MEM]) begin
                    imm = ($urandom_range(11) == 0) ? $urandom : $urandom_range(63);
                    if (t[BIT_REG] && idx < 4) imm -= sb.regs[idx];
                end else begin
                    imm = corner();
                end
                if (t[BIT_REG]) args[n++] = idx;
                if (t[BIT_IMM] && t != ARG_REG) args[n++] = imm;
            end
        end else if (op >= OP_JMP && op <= OP_CALL) begin
            args[n++] = $urandom_range(95);
        end
        w = {24'($urandom), t, op};
        if (w == 0) w = mk(OP_ADD, 3'b000);
        run_instr(n + 1, w, args[0], args[1], corner());
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // wraparound, MIN / -1, divide by zero, stack underflow, bad argument and opcode, jumps, call and return
        run_instr(2, mk(OP_PUSH, 3'b001), 32'h7FFF_FFFF, 0, 0);
        run_instr(2, mk(OP_PUSH, 3'b001), 32'h1, 0, 0);
        run_instr(1, mk(OP_ADD, 3'b000), 0, 0, 0);
        run_instr(1, mk(OP_IN, 3'b000), 0, 0, 32'hFFFF_FFFF);
        run_instr(1, mk(OP_DIV, 3'b000), 0, 0, 0);
        run_instr(1, mk(OP_OUT, 3'b000), 0, 0, 0);
        run_instr(2, mk(OP_PUSH, 3'b001), 32'd7, 0, 0);
        run_instr(2, mk(OP_PUSH, 3'b001), 32'd0, 0, 0);
        run_instr(1, mk(OP_DIV, 3'b000), 0, 0, 0);
        run_instr(2, mk(OP_POP, 3'b010), 32'd2, 0, 0);
        run_instr(3, mk(OP_POP, 3'b101), 0, 32'd63, 0);
        run_instr(1, mk(OP_OUT, 3'b000), 0, 0, 0);
        run_instr(3, mk(OP_PUSH, 3'b111), 32'd2, 32'd56, 0);
        run_instr(2, mk(OP_PUSH, 3'b010), 32'd2, 0, 0);
        run_instr(2, mk(OP_PUSH, 3'b110), 32'd3, 0, 0);
        run_instr(2, mk(OP_JB, 3'b000), 32'd40, 0, 0);
        run_instr(1, mk(5'd31, 3'b111), 0, 0, 0);
        run_instr(1, mk(OP_PUSH, 3'b000), 0, 0, 0);
        run_instr(2, mk(OP_PUSH, 3'b010), 32'd9, 0, 0);
        run_instr(1, mk(OP_RET, 3'b000), 0, 0, 0);
        run_instr(2, mk(OP_CALL, 3'b000), 32'd70, 0, 0);
        run_instr(1, mk(OP_RET, 3'b000), 0, 0, 0);
        run_instr(1, mk(OP_OUT, 3'b000), 0, 0, 0);

        while (items < 1050) begin
            if (items % 160 < 4) mode = $urandom_range(3);
            if (items > 520 && items < 530) begin
                s_tvalid <= 1'b0;
                while (sb.pending_q.size() != 0) @(posedge aclk);
            end
            quiet = items > 900;
            random_instr();
        end

        // halting: hlt, an end word, or a jump past the executable range
        case ($urandom_range(2))
            0: run_instr(1, mk(OP_HLT, 3'($urandom)), 0, 0, 0);
            1: run_instr(1, 32'h0, 0, 0, 0);
            default: begin
                run_instr(2, mk(OP_JMP, 3'b000), $urandom_range(100, 127), 0, 0);
                send(1, 7'd0, 32'd0, 32'd0);
            end
        endcase
        send(1, 7'($urandom), $urandom, $urandom);
        send(1, 7'($urandom), $urandom, $urandom);
        s_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Run: %0d transactions (%0d loads, %0d steps), %0d results, %0d mismatches",
                 items, sb.loads, sb.steps, sb.results, sb.errors);
        $display("Status mix: ok %0d out %0d halt %0d badarg %0d badop %0d fault %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
